// ----- sv/bsc_pkg.sv -----
// Shared types and constants for the bitmap scan/clear and range fill unit.
package bsc_pkg;

  localparam int IDX_W  = 11;  // index and start field width (signed)
  localparam int LEN_W  = 11;  // length field width
  localparam int SIZE_W = 11;  // size register width
  localparam int EXT_W  = 12;  // internal index arithmetic, holds start + length

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [IDX_W-1:0]  IDX_NONE   = 11'h7FF;  // -1

  typedef enum logic [1:0] {
    ACT_SCAN = 2'd0,
    ACT_SET  = 2'd1,
    ACT_CLR  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

endpackage

// ----- sv/bsc_word_eval.sv -----
// One bitmap word: range mask, lowest set bit search and updated word value.
module bsc_word_eval
  import bsc_pkg::*;
#(
  parameter int WORD_BITS = 64,
  localparam int BP_W = $clog2(WORD_BITS)
) (
  input  action_t                action,
  input  logic [BP_W-1:0]        lo_off,
  input  logic [BP_W-1:0]        hi_off,
  input  logic [WORD_BITS-1:0]   word_in,
  output logic [WORD_BITS-1:0]   word_out,
  output logic                   hit,
  output logic [BP_W-1:0]        hit_pos
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] hit_bit;

  // bits lo_off..hi_off inclusive are active in this word
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (BP_W'(i) >= lo_off) && (BP_W'(i) <= hi_off);
    end
  end

  assign cand = word_in & mask;
  assign hit  = |cand;

  // lowest set bit wins
  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_pos = BP_W'(i);
      end
    end
  end

  assign hit_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << hit_pos;

  always_comb begin
    unique case (action)
      ACT_SCAN: word_out = hit ? (word_in & ~hit_bit) : word_in;
      ACT_SET:  word_out = word_in | mask;
      ACT_CLR:  word_out = word_in & ~mask;
      default:  word_out = word_in;
    endcase
  end

endmodule

// ----- sv/bitmap_scan_clear_and_range_fill_unit.sv -----
// Top level of the bitmap scan/clear and range fill unit.
//
// The bitmap of NUM_BITS bits lives in one synchronous RAM of NUM_BITS/WORD_BITS
// words (WORD_BITS a power of two) with a registered read. After reset a
// clearing pass writes zero to every word, one word a cycle; requests are held
// off during it, config writes are taken at any time. Each request is worked by
// a read-modify-write walk over the words it touches, one word per cycle, with
// the next word's read overlapped with the current word's update. After
// acceptance a start state decodes the request and issues the first read, the
// walk state updates the words, and a result state hands the result to the
// output register once it is free; a request that touches no word (scan starting
// at or past the size, out-of-range range start, zero length, unused action)
// goes from the start state straight to the result state. The unit then returns
// to idle, so one request is worked at a time. At the defaults a full scan walks
// 16 words. A new request is accepted once the previous result has moved into
// the output register, so a result waiting on out_ready does not block the next
// request. size_in_use above NUM_BITS acts as NUM_BITS; bits at or above the
// size are never found or altered.
module bitmap_scan_clear_and_range_fill_unit
  import bsc_pkg::*;
#(
  parameter int NUM_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // config write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_size_in_use,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic signed [IDX_W-1:0] in_start_req,
  input  logic [LEN_W-1:0]        in_length,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [IDX_W-1:0] out_found_index,
  output logic                    out_error
);

  localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BP_W      = $clog2(WORD_BITS);
  localparam logic [31:0]     NUM_BITS_U = 32'(NUM_BITS);
  localparam logic [WA_W-1:0] LAST_WORD  = WA_W'(NUM_WORDS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_START  = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [WA_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [SIZE_W-1:0] size_r;

  // request latched at acceptance
  action_t           action_r;
  logic [IDX_W-1:0]  start_r;
  logic [LEN_W-1:0]  len_r;

  // walk bounds: bits lo_r .. hi_r-1
  logic [EXT_W-1:0]  lo_r, lo_nxt;
  logic [EXT_W-1:0]  hi_r, hi_nxt;
  logic [WA_W-1:0]   first_w_r, first_w_nxt;
  logic [WA_W-1:0]   last_w_r, last_w_nxt;
  logic [WA_W-1:0]   cur_w_r, cur_w_nxt;

  logic [IDX_W-1:0]  res_found_r, res_found_nxt;
  logic              res_err_r, res_err_nxt;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_found_r;
  logic              out_err_r;
  logic              out_free;

  // memory
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en, wr_en;
  logic [WA_W-1:0]      rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // start-of-request decode
  logic [EXT_W-1:0] eff_size;
  logic             start_neg;
  logic [EXT_W-1:0] start_ext;
  logic [EXT_W-1:0] scan_b0;
  logic [EXT_W-1:0] range_end;
  logic [EXT_W-1:0] range_clip;
  logic             walk_go;
  logic             walk_err;
  logic [EXT_W-1:0] walk_lo;
  logic [EXT_W-1:0] walk_hi;

  // word evaluation
  logic [EXT_W-1:0]     hi_m1;
  logic [BP_W-1:0]      lo_off, hi_off;
  logic [WORD_BITS-1:0] word_out;
  logic                 hit;
  logic [BP_W-1:0]      hit_pos;
  logic [IDX_W-1:0]     found_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_r;
  assign out_error       = out_err_r;

  // size above the bitmap acts as the whole bitmap
  assign eff_size = (32'(size_r) > NUM_BITS_U) ? EXT_W'(NUM_BITS_U) : EXT_W'(size_r);

  assign start_neg  = start_r[IDX_W-1];
  assign start_ext  = {1'b0, start_r};
  assign scan_b0    = start_neg ? '0 : start_ext + EXT_W'(1);
  assign range_end  = start_ext + EXT_W'(len_r);
  assign range_clip = (range_end > eff_size) ? eff_size : range_end;

  always_comb begin
    walk_go  = 1'b0;
    walk_err = 1'b0;
    walk_lo  = start_ext;
    walk_hi  = range_clip;
    case (action_r)
      ACT_SCAN: begin
        walk_lo = scan_b0;
        walk_hi = eff_size;
        walk_go = (scan_b0 < eff_size);
      end
      ACT_SET, ACT_CLR: begin
        if (start_neg || (start_ext >= eff_size)) begin
          walk_err = 1'b1;
        end else begin
          walk_go = (range_clip > start_ext);
        end
      end
      default: ;
    endcase
  end

  // per-word active bit window
  assign hi_m1  = hi_r - EXT_W'(1);
  assign lo_off = (cur_w_r == first_w_r) ? lo_r[BP_W-1:0] : '0;
  assign hi_off = (cur_w_r == last_w_r) ? hi_m1[BP_W-1:0] : '1;

  bsc_word_eval #(
    .WORD_BITS (WORD_BITS)
  ) u_word_eval (
    .action   (action_r),
    .lo_off   (lo_off),
    .hi_off   (hi_off),
    .word_in  (rd_data_r),
    .word_out (word_out),
    .hit      (hit),
    .hit_pos  (hit_pos)
  );

  assign found_idx = IDX_W'((EXT_W'(cur_w_r) << BP_W) | EXT_W'(hit_pos));

  // control
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    first_w_nxt   = first_w_r;
    last_w_nxt    = last_w_r;
    cur_w_nxt     = cur_w_r;
    res_found_nxt = res_found_r;
    res_err_nxt   = res_err_r;
    rd_en         = 1'b0;
    rd_addr       = cur_w_r + WA_W'(1);
    wr_en         = 1'b0;
    wr_addr       = cur_w_r;
    wr_data       = word_out;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (clr_cnt_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + WA_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        res_found_nxt = IDX_NONE;
        res_err_nxt   = walk_err;
        state_nxt     = ST_RESULT;
        if (walk_go) begin
          lo_nxt      = walk_lo;
          hi_nxt      = walk_hi;
          first_w_nxt = WA_W'(walk_lo >> BP_W);
          last_w_nxt  = WA_W'((walk_hi - EXT_W'(1)) >> BP_W);
          cur_w_nxt   = WA_W'(walk_lo >> BP_W);
          rd_en       = 1'b1;
          rd_addr     = WA_W'(walk_lo >> BP_W);
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (action_r == ACT_SCAN) begin
          if (hit) begin
            wr_en         = 1'b1;
            res_found_nxt = found_idx;
            state_nxt     = ST_RESULT;
          end else if (cur_w_r == last_w_r) begin
            state_nxt = ST_RESULT;
          end else begin
            rd_en     = 1'b1;
            cur_w_nxt = cur_w_r + WA_W'(1);
          end
        end else begin
          wr_en = 1'b1;
          if (cur_w_r == last_w_r) begin
            state_nxt = ST_RESULT;
          end else begin
            rd_en     = 1'b1;
            cur_w_nxt = cur_w_r + WA_W'(1);
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_size_in_use;
      end
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r <= action_t'(in_action);
      start_r  <= in_start_req;
      len_r    <= in_length;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    first_w_r   <= first_w_nxt;
    last_w_r    <= last_w_nxt;
    cur_w_r     <= cur_w_nxt;
    res_found_r <= res_found_nxt;
    res_err_r   <= res_err_nxt;
    if (state_r == ST_RESULT && out_free) begin
      out_found_r <= res_found_r;
      out_err_r   <= res_err_r;
    end
  end

  // bitmap RAM, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // checks
  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same word in one cycle");

  a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cur_w_r <= last_w_r))
    else $error("walk past last word");

  a_found_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && action_r == ACT_SCAN && hit) |->
      ({1'b0, found_idx} < hi_r))
    else $error("scan hit at or past the size");

  a_err_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_found_r == IDX_NONE))
    else $error("error result carries an index");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_free) |=> (out_valid_r && out_found_r == $past(res_found_r)))
    else $error("result not moved to output register");

endmodule
